// ----- design/mh2_pkg.sv -----
package mh2_pkg;

    localparam logic [31:0] MIX_MUL = 32'h5bd1e995;
    localparam int unsigned MIX_SHIFT = 24;
    localparam int unsigned FIN_SHIFT_A = 13;
    localparam int unsigned FIN_SHIFT_B = 15;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 3);

    // item classes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TAIL = 2'd1;
    localparam logic [1:0] KIND_FULL = 2'd2;

    // register index (byte address bit 2)
    localparam logic REG_SEED = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic        first;
        logic        last;
        logic [31:0] len;
        logic [31:0] key;
    } t_item;

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return prod[31:0];
    endfunction

endpackage

// ----- design/mh2_front.sv -----
module mh2_front
    import mh2_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [31:0]            i_data_word,
    input  logic [2:0]             i_byte_count,
    input  logic                   i_first_item,
    input  logic                   i_last_item,
    input  logic [31:0]            i_message_length,
    input  logic [QUEUE_CNT_W-1:0] i_queue_count,
    output logic                   o_push,
    output t_item                  o_item
);

    logic        r_s1_valid;
    t_item       r_s1_item;
    logic        r_s2_valid;
    t_item       r_s2_item;
    t_item       n_s1_item;
    t_item       n_s2_item;
    logic        accept;
    logic [31:0] mixed;
    logic [QUEUE_CNT_W-1:0] used;

    // reserve a queue slot for every item still in the front stages
    assign used = i_queue_count + QUEUE_CNT_W'(r_s1_valid) + QUEUE_CNT_W'(r_s2_valid);
    assign o_ready = (used < QUEUE_CNT_W'(QUEUE_DEPTH));
    assign accept = i_valid && o_ready;

    always_comb begin
        n_s1_item.first = i_first_item;
        n_s1_item.last  = i_last_item;
        n_s1_item.len   = i_message_length;
        case (i_byte_count)
            3'd0: begin
                n_s1_item.kind = KIND_NONE;
                n_s1_item.key  = 32'd0;
            end
            3'd1: begin
                n_s1_item.kind = KIND_TAIL;
                n_s1_item.key  = {24'd0, i_data_word[7:0]};
            end
            3'd2: begin
                n_s1_item.kind = KIND_TAIL;
                n_s1_item.key  = {16'd0, i_data_word[15:0]};
            end
            3'd3: begin
                n_s1_item.kind = KIND_TAIL;
                n_s1_item.key  = {8'd0, i_data_word[23:0]};
            end
            default: begin
                n_s1_item.kind = KIND_FULL;
                n_s1_item.key  = mul32(i_data_word, MIX_MUL);
            end
        endcase
    end

    always_comb begin
        mixed = r_s1_item.key ^ (r_s1_item.key >> MIX_SHIFT);
        n_s2_item = r_s1_item;
        if (r_s1_item.kind == KIND_FULL) begin
            n_s2_item.key = mul32(mixed, MIX_MUL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= n_s1_item;
        r_s2_item <= n_s2_item;
    end

    assign o_push = r_s2_valid;
    assign o_item = r_s2_item;

endmodule

// ----- design/mh2_queue.sv -----
module mh2_queue
    import mh2_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  t_item                  i_item,
    input  logic                   i_pop,
    output t_item                  o_item,
    output logic                   o_empty,
    output logic [QUEUE_CNT_W-1:0] o_count
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> (!i_push || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- design/mh2_back.sv -----
module mh2_back
    import mh2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_seed,
    input  t_item       i_item,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_FIN = 1'b1;

    logic        r_state;
    logic        n_state;
    logic [31:0] r_hash;
    logic [31:0] n_hash;
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic [31:0] h_start;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic        out_free;
    logic        fin_fire;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == ST_RUN) && !i_empty;
    assign fin_fire = (r_state == ST_FIN) && out_free;

    assign h_start = i_item.first ? (i_seed ^ i_item.len) : r_hash;

    // one multiplier, shared by the fold and the finalization
    always_comb begin
        if (r_state == ST_FIN) begin
            mul_a = r_hash ^ (r_hash >> FIN_SHIFT_A);
        end else if (i_item.kind == KIND_FULL) begin
            mul_a = h_start;
        end else begin
            mul_a = h_start ^ i_item.key;
        end
        prod = mul32(mul_a, MIX_MUL);
    end

    always_comb begin
        n_state = r_state;
        n_hash  = r_hash;
        unique case (r_state)
            ST_RUN: begin
                if (o_pop) begin
                    unique case (i_item.kind)
                        KIND_FULL: n_hash = prod ^ i_item.key;
                        KIND_TAIL: n_hash = prod;
                        default:   n_hash = h_start;
                    endcase
                    if (i_item.last) begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_hash      <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hash  <= n_hash;
            if (fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_hash <= prod ^ (prod >> FIN_SHIFT_B);
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_out_hash;

`ifndef SYNTHESIS
    a_no_pop_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> !o_pop)
        else $error("item popped during finalization");
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside finalization");
    a_fin_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_item.last) |=> (r_state == ST_RUN))
        else $error("finalization entered without a last item");
`endif

endmodule

// ----- design/murmur2_hash32.sv -----
// Streaming 32-bit MurmurHash2.
// Input channel (i_valid / o_ready): one item per message word, first byte in
// bits 7:0. i_first_item loads the hash with seed ^ i_message_length; full
// words (byte count 4 or more) are mixed and folded, 1 to 3 bytes take the tail
// step, a byte count of 0 leaves the hash unchanged. i_last_item requests the
// finalized hash on the output channel (o_valid / i_ready).
// Seed register at APB byte address 0; pready is always high.
// Throughput: one item per cycle in steady state. The key mixing runs in a
// two-stage front pipeline; the hash fold uses one multiplier in the back end,
// which also does the finalization multiply, so a last item holds the back end
// in finalization before it pops again; the result and o_valid are registered.
// A four-entry queue sits between front and back; o_ready drops when the
// queue plus the front stages hold four items. If the receiver stalls, the
// result holds in the output register, the back end waits in finalization and
// the queue fills, after which input is refused.
// Reset clears the seed, the running hash, the queue and all valid flags.
module murmur2_hash32
    import mh2_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_first_item,
    input  logic        i_last_item,
    input  logic [31:0] i_message_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0]            r_seed;
    logic                   push;
    logic                   pop;
    logic                   empty;
    t_item                  front_item;
    t_item                  queue_item;
    logic [QUEUE_CNT_W-1:0] queue_count;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SEED)) begin
            r_seed <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? r_seed : 32'd0;

    mh2_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_word      (i_data_word),
        .i_byte_count     (i_byte_count),
        .i_first_item     (i_first_item),
        .i_last_item      (i_last_item),
        .i_message_length (i_message_length),
        .i_queue_count    (queue_count),
        .o_push           (push),
        .o_item           (front_item)
    );

    mh2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_empty (empty),
        .o_count (queue_count)
    );

    mh2_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (r_seed),
        .i_item       (queue_item),
        .i_empty      (empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hash_value (o_hash_value)
    );

endmodule
